// ===== rtl/naive_pattern_match_stats_unit_defines.svh =====
// assertion macros for the naive pattern match statistics unit
// used by the top level only; expects clk and rst_n in scope
`ifndef NAIVE_PATTERN_MATCH_STATS_UNIT_DEFINES_SVH
`define NAIVE_PATTERN_MATCH_STATS_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NPMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npms: same-cycle check failed");

// next-cycle implication, checked out of reset
`define NPMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npms: next-cycle check failed");

`endif

// ===== rtl/npms_pkg.sv =====
// shared types and constants for the naive pattern match statistics unit
// no dependencies; imported by npms_cell, npms_stats and the top level
`timescale 1ns / 1ps

package npms_pkg;

    // default sizes
    localparam int PATTERN_MAX_DEF = 16;
    localparam int TEXT_MAX_DEF    = 65535;

    // pattern storage
    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = 8 * PAT_BYTES;
    localparam int CHAR_W    = 8;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    // result field widths
    localparam int CNT_W     = 5;
    localparam int OFFSET_W  = 17;
    localparam int TOTAL_W   = 16;
    localparam int COMPARE_W = 21;
    localparam int OUT_W     = 80;

    // alignment held by one cell
    typedef struct packed {
        logic             valid;
        logic             failed;
        logic [CNT_W-1:0] progress;
        logic [CNT_W-1:0] compares;
    } cell_state_t;

    // alignment that closes on the current item
    typedef struct packed {
        logic             done;
        logic             full;
        logic [CNT_W-1:0] progress;
        logic [CNT_W-1:0] compares;
    } cell_report_t;

    // per-text statistics
    typedef struct packed {
        logic                 text_too_long;
        logic [COMPARE_W-1:0] chars_compared;
        logic [CNT_W-1:0]     longest_prefix;
        logic [TOTAL_W-1:0]   match_total;
        logic [OFFSET_W-1:0]  last_offset;
        logic [OFFSET_W-1:0]  first_offset;
    } result_t;

    // handshake events seen by the statistics unit
    typedef struct packed {
        logic accept;
        logic last;
    } item_ctl_t;

endpackage

// ===== rtl/npms_cell.sv =====
// one alignment cell of the comparison chain
// depends on npms_pkg; the cell at position INDEX sees alignments of age INDEX
`timescale 1ns / 1ps

module npms_cell #(
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          clear,
    input  logic [npms_pkg::CHAR_W-1:0]   text_byte,
    input  logic [npms_pkg::CHAR_W-1:0]   pat_byte,
    input  logic [npms_pkg::CNT_W-1:0]    used_len,
    input  npms_pkg::cell_state_t         state_in,
    output npms_pkg::cell_state_t         state_out,
    output npms_pkg::cell_report_t        report
);
    import npms_pkg::*;

    localparam logic [CNT_W-1:0] AGE = CNT_W'(INDEX);

    cell_state_t state_reg;
    cell_state_t state_next;
    cell_state_t upd;

    // compare this item against the pattern byte for this age
    always_comb
    begin
        upd        = state_in;
        state_next = state_in;
        report     = '0;
        if (!state_in.valid)
        begin
            state_next.valid = 1'b0;
        end
        else if (AGE >= used_len)
        begin
            // pattern shrank under a live alignment: drop it uncounted
            state_next.valid = 1'b0;
        end
        else
        begin
            if (!state_in.failed)
            begin
                upd.compares = state_in.compares + 1'b1;
                if (text_byte == pat_byte)
                    upd.progress = state_in.progress + 1'b1;
                else
                    upd.failed = 1'b1;
            end
            state_next = upd;
            if (AGE == used_len - 1'b1)
            begin
                report.done      = 1'b1;
                report.full      = (upd.progress == used_len);
                report.progress  = upd.progress;
                report.compares  = upd.compares;
                state_next.valid = 1'b0;
            end
        end
    end

    // hand the aged alignment to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (clear)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    assign state_out = state_reg;

endmodule

// ===== rtl/npms_stats.sv =====
// per-text statistics: position, match offsets, counts, compare total
// depends on npms_pkg; fed by the report of the cell chain
`timescale 1ns / 1ps

module npms_stats #(
    parameter int TEXT_MAX = npms_pkg::TEXT_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  npms_pkg::item_ctl_t        ctl,
    input  npms_pkg::cell_report_t     report,
    input  logic [npms_pkg::CNT_W-1:0] used_len,
    output logic                       take,
    output npms_pkg::result_t          result
);
    import npms_pkg::*;

    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int EXT_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
    localparam logic [TOTAL_W-1:0]   HIT_SAT = {TOTAL_W{1'b1}};
    localparam logic [COMPARE_W:0]   CMP_SAT = {1'b0, {COMPARE_W{1'b1}}};

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    result_t              stat_reg;
    result_t              stat_next;
    result_t              stat_clear;
    logic                 pos_full;
    logic                 hit;
    logic                 closed;
    logic [EXT_W-1:0]     diff;
    logic [OFFSET_W-1:0]  offset;
    logic [COMPARE_W:0]   cmp_sum;

    assign pos_full = (pos_reg == POS_W'(TEXT_MAX));
    assign take     = ctl.accept && !pos_full;
    assign closed   = take && report.done;
    assign hit      = closed && report.full;

    // start offset of the alignment that closes now
    assign diff   = EXT_W'(pos_reg) - EXT_W'(used_len - 1'b1);
    assign offset = diff[OFFSET_W-1:0];

    assign cmp_sum = {1'b0, stat_reg.chars_compared} + (COMPARE_W + 1)'(report.compares);

    // values after this item
    always_comb
    begin
        stat_next = stat_reg;
        pos_next  = take ? pos_reg + 1'b1 : pos_reg;
        if (ctl.accept && pos_full)
            stat_next.text_too_long = 1'b1;
        if (hit)
        begin
            if (stat_reg.match_total == '0)
                stat_next.first_offset = offset;
            stat_next.last_offset = offset;
            if (stat_reg.match_total != HIT_SAT)
                stat_next.match_total = stat_reg.match_total + 1'b1;
        end
        if (closed)
        begin
            if (report.progress > stat_reg.longest_prefix)
                stat_next.longest_prefix = report.progress;
            stat_next.chars_compared = (cmp_sum > CMP_SAT) ? CMP_SAT[COMPARE_W-1:0]
                                                            : cmp_sum[COMPARE_W-1:0];
        end
    end

    // per-text reset values
    always_comb
    begin
        stat_clear              = '0;
        stat_clear.first_offset = '1;
        stat_clear.last_offset  = '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            stat_reg <= stat_clear;
        end
        else if (ctl.accept && ctl.last)
        begin
            pos_reg  <= '0;
            stat_reg <= stat_clear;
        end
        else if (ctl.accept)
        begin
            pos_reg  <= pos_next;
            stat_reg <= stat_next;
        end
    end

    assign result = stat_next;

endmodule

// ===== rtl/naive_pattern_match_stats_unit.sv =====
// naive pattern match statistics unit: top level with chain, stats and output stage
// depends on npms_pkg, npms_cell, npms_stats and the defines header
//
// usage:
//   text bytes arrive on s_axis (tdata = text_byte, tlast marks the last byte).
//   the pattern (1 to 16 bytes) and its length are set through cfg_wen /
//   cfg_addr / cfg_wdata while the unit is idle: index 0 holds pattern bytes
//   0..7, index 1 bytes 8..15, index 2 the length.
//   one byte is taken per cycle; a row of PATTERN_MAX cells holds every open
//   alignment, each cell comparing its byte and passing its alignment on.
//   after the byte marked last, one statistics item appears on m_axis in the
//   next cycle; other bytes produce nothing.
//   a single output register sits between the sides: input is taken while the
//   output is empty or being drained, so a stalled receiver holds the result
//   and stops input only while that result waits.
//   bytes past TEXT_MAX are dropped and set text_too_long.
//   reset clears all cells and statistics and sets the pattern length to 1.
`timescale 1ns / 1ps
`include "naive_pattern_match_stats_unit_defines.svh"

module naive_pattern_match_stats_unit #(
    parameter int PATTERN_MAX = npms_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = npms_pkg::TEXT_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_wen,
    input  logic [npms_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [npms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // text input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
    input  logic                              s_axis_tlast,  // text_last
    // statistics output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [16:0] first_offset, [33:17] last_offset, [49:34] match_total,
    // [54:50] longest_prefix, [75:55] chars_compared, [76] text_too_long, rest zero
    output logic [npms_pkg::OUT_W-1:0]        m_axis_tdata
);
    import npms_pkg::*;

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [CNT_W-1:0]      pat_len_reg;
    logic [PAT_W-1:0]      pattern;
    logic [CNT_W-1:0]      used_len;

    logic                  accept;
    logic                  take;
    item_ctl_t             ctl;
    cell_state_t           chain_state [PATTERN_MAX];
    cell_report_t          reports [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] done_vec;
    cell_report_t          report_any;
    result_t               result;

    logic                  out_valid_reg;
    result_t               out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= CNT_W'(1);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_wdata;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_wdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign pattern = {pat_high_reg, pat_low_reg};

    // clamp the length into 1..PATTERN_MAX
    always_comb
    begin
        priority if (pat_len_reg == '0)
            used_len = CNT_W'(1);
        else if (pat_len_reg > CNT_W'(PATTERN_MAX))
            used_len = CNT_W'(PATTERN_MAX);
        else
            used_len = pat_len_reg;
    end

    // handshake
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctl.accept    = accept;
    assign ctl.last      = s_axis_tlast;

    // row of alignment cells, a fresh alignment enters cell 0 on every taken byte
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        cell_state_t cin;
        if (k == 0)
        begin : g_head
            assign cin = '{valid: 1'b1, failed: 1'b0, progress: '0, compares: '0};
        end
        else
        begin : g_body
            assign cin = chain_state[k-1];
        end
        npms_cell #(
            .INDEX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (take),
            .clear     (accept && s_axis_tlast),
            .text_byte (s_axis_tdata),
            .pat_byte  (pattern[CHAR_W*k +: CHAR_W]),
            .used_len  (used_len),
            .state_in  (cin),
            .state_out (chain_state[k]),
            .report    (reports[k])
        );
        assign done_vec[k] = reports[k].done;
    end

    // at most one cell closes per byte, so merge by or
    always_comb
    begin
        report_any = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
            report_any = report_any | reports[k];
    end

    npms_stats #(
        .TEXT_MAX (TEXT_MAX)
    ) u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .report   (report_any),
        .used_len (used_len),
        .take     (take),
        .result   (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_W - 77)'(0),
        out_reg.text_too_long,
        out_reg.chars_compared,
        out_reg.longest_prefix,
        out_reg.match_total,
        out_reg.last_offset,
        out_reg.first_offset
    };

    // checks
    `NPMS_ASSERT_NOW(a_tail_cell_empty, 1'b1, !chain_state[PATTERN_MAX-1].valid)
    `NPMS_ASSERT_NOW(a_single_close, 1'b1, $countones(done_vec) <= 1)
    `NPMS_ASSERT_NEXT(a_result_follows_last, accept && s_axis_tlast, m_axis_tvalid)

endmodule
